// ===== hdl/gslc_pkg.sv =====
// Package for the glyph slot LRU cache: stream payload types, register
// indexes and field widths. No dependencies.
package gslc_pkg;

    localparam int KEY_W   = 32;
    localparam int CODE_W  = 16;
    localparam int SIZE_W  = 8;
    localparam int COORD_W = 9;
    localparam int BS_W    = 7;
    localparam int CPR_W   = 4;
    localparam int CFG_W   = 7;

    // tdata in: char_code, font_type, glyph_width, glyph_height (48 bits)
    typedef logic [47:0] in_data_t;
    // tdata out: cell_x, cell_y, stored_width, stored_height, 6 zero pad (40 bits)
    typedef logic [39:0] out_data_t;

    typedef logic [0:0] cfg_index_t;
    typedef logic [CFG_W-1:0] cfg_data_t;

    localparam cfg_index_t REG_BLOCK_SIZE    = 1'd0;
    localparam cfg_index_t REG_CELLS_PER_ROW = 1'd1;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

endpackage

// ===== hdl/glyph_slot_lru_cache.sv =====
// Glyph slot LRU cache top level: fully associative key store, recency list,
// sequencer and shared divide/multiply unit. Depends on gslc_pkg.
//
// Usage:
//   s_* channel takes one transaction per lookup or clear. s_tuser is func
//   (0 lookup, 1 clear); s_tdata carries key halves and glyph size.
//   m_* channel returns one transaction per input: m_tuser is hit, m_tdata
//   carries cell_x, cell_y and the slot's stored glyph size.
//   cfg_we/cfg_index/cfg_data write block_size (0) and cells_per_row (1);
//   a write rebuilds the whole cache with the new geometry.
// Sequence:
//   A lookup walks the recency list through ST_ORD, ST_KEY and ST_CMP per position
//   until a match or the oldest slot, then shifts the list through ST_SH_RD and
//   ST_SH_WR per position moved, then divides the slot number by cells_per_row
//   with one restoring step per quotient bit and multiplies twice. A clear
//   zeroes every slot's key. Each memory has one read and one write port.
// Reset and configuration: an init sweep rewrites every
//   slot; s_tready stays low during it.
// Stall: the result sits in an output register; one more item can be
//   processed while it waits, then the sequencer holds until m_tready.
module glyph_slot_lru_cache #(
    parameter int ENTRIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gslc_pkg::in_data_t   s_tdata,   // char_code, font_type, glyph_width, glyph_height
    input  logic                 s_tuser,   // func
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output gslc_pkg::out_data_t  m_tdata,   // cell_x, cell_y, stored_width, stored_height
    output logic                 m_tuser,   // hit
    input  logic                 cfg_we,
    input  gslc_pkg::cfg_index_t cfg_index,
    input  gslc_pkg::cfg_data_t  cfg_data
);
    import gslc_pkg::*;

    localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int DCW = $clog2(AW + 1);
    localparam int MW  = AW + CPR_W;
    localparam int PW  = MW + BS_W;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_CLEAR, ST_ORD, ST_KEY, ST_CMP, ST_UPD,
        ST_SH_RD, ST_SH_WR, ST_TOP, ST_DIV, ST_MULX, ST_MULY, ST_DONE
    } state_t;

    state_t              state_reg;
    logic [BS_W-1:0]     bs_reg;
    logic [CPR_W-1:0]    cpr_reg;
    logic [AW-1:0]       swp_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       slot_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [SIZE_W-1:0]   gw_reg;
    logic [SIZE_W-1:0]   gh_reg;
    logic                hit_reg;
    logic                zero_reg;
    logic [AW-1:0]       quo_reg;
    logic [CPR_W-1:0]    rem_reg;
    logic [DCW-1:0]      cnt_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic                m_tvalid_reg;
    logic                m_tuser_reg;
    out_data_t           m_tdata_reg;

    // memories and their registered read data
    logic [KEY_W-1:0]  key_mem [ENTRIES];
    logic [SIZE_W-1:0] w_mem   [ENTRIES];
    logic [SIZE_W-1:0] h_mem   [ENTRIES];
    logic [AW-1:0]     ord_mem [ENTRIES];
    logic [KEY_W-1:0]  key_rd_reg;
    logic [SIZE_W-1:0] w_rd_reg;
    logic [SIZE_W-1:0] h_rd_reg;
    logic [AW-1:0]     ord_rd_reg;

    logic              key_we;
    logic [AW-1:0]     key_wa;
    logic [KEY_W-1:0]  key_wd;
    logic              hw_we;
    logic [AW-1:0]     hw_wa;
    logic [SIZE_W-1:0] w_wd;
    logic [SIZE_W-1:0] h_wd;
    logic              ord_we;
    logic [AW-1:0]     ord_wa;
    logic [AW-1:0]     ord_wd;
    logic [AW-1:0]     ord_ra;

    logic [7:0]        n_full;
    logic [CW-1:0]     active_cnt;
    logic [AW-1:0]     last_pos;
    logic [CW-1:0]     swp_ext;
    logic [AW-1:0]     init_ord;
    logic              key_match;
    logic [CPR_W:0]    rem_sh;
    logic              div_ge;
    logic [MW-1:0]     mul_op;
    logic [PW-1:0]     prod;

    always_comb
    begin
        n_full     = 8'(cpr_reg) * 8'(cpr_reg);
        active_cnt = (32'(n_full) > ENTRIES) ? CW'(ENTRIES) : CW'(n_full);
        last_pos   = AW'(active_cnt - CW'(1));
        swp_ext    = CW'(swp_reg);
        init_ord   = (swp_ext < active_cnt) ? AW'(active_cnt - CW'(1) - swp_ext) : '0;
        key_match  = (key_rd_reg == key_reg);
        rem_sh     = {rem_reg, quo_reg[AW-1]};
        div_ge     = (rem_sh >= {1'b0, cpr_reg});
        mul_op     = (state_reg == ST_MULX) ? MW'(rem_reg) : MW'(quo_reg);
        prod       = PW'(mul_op) * PW'(bs_reg);
    end

    always_comb
    begin
        key_we = 1'b0;
        key_wa = swp_reg;
        key_wd = '0;
        hw_we  = 1'b0;
        hw_wa  = swp_reg;
        w_wd   = '0;
        h_wd   = '0;
        ord_we = 1'b0;
        ord_wa = swp_reg;
        ord_wd = init_ord;
        ord_ra = (state_reg == ST_SH_RD) ? pos_reg - AW'(1) : pos_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                key_we = 1'b1;
                hw_we  = 1'b1;
                ord_we = 1'b1;
            end
            ST_CLEAR:
            begin
                key_we = 1'b1;
            end
            ST_UPD:
            begin
                key_we = !hit_reg;
                hw_we  = !hit_reg;
                key_wa = slot_reg;
                hw_wa  = slot_reg;
                key_wd = key_reg;
                w_wd   = gw_reg;
                h_wd   = gh_reg;
            end
            ST_SH_WR:
            begin
                ord_we = 1'b1;
                ord_wa = pos_reg;
                ord_wd = ord_rd_reg;
            end
            ST_TOP:
            begin
                ord_we = 1'b1;
                ord_wa = '0;
                ord_wd = slot_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd_reg <= key_mem[ord_rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hw_we)
        begin
            w_mem[hw_wa] <= w_wd;
            h_mem[hw_wa] <= h_wd;
        end
        w_rd_reg <= w_mem[slot_reg];
        h_rd_reg <= h_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd_reg <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            bs_reg       <= BS_W'(16);
            cpr_reg      <= CPR_W'(8);
            swp_reg      <= '0;
            pos_reg      <= '0;
            slot_reg     <= '0;
            key_reg      <= '0;
            gw_reg       <= '0;
            gh_reg       <= '0;
            hit_reg      <= 1'b0;
            zero_reg     <= 1'b0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            cnt_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    swp_reg <= swp_reg + AW'(1);
                    if (swp_reg == AW'(ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        key_reg  <= {s_tdata[31:16], s_tdata[15:0]};
                        gw_reg   <= s_tdata[39:32];
                        gh_reg   <= s_tdata[47:40];
                        pos_reg  <= '0;
                        swp_reg  <= '0;
                        zero_reg <= 1'b1;
                        if (s_tuser == FUNC_CLEAR)
                        begin
                            state_reg <= ST_CLEAR;
                        end
                        else if (active_cnt == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= ST_ORD;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    swp_reg <= swp_reg + AW'(1);
                    if (swp_reg == AW'(ENTRIES - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_ORD:
                begin
                    state_reg <= ST_KEY;
                end
                ST_KEY:
                begin
                    slot_reg  <= ord_rd_reg;
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    hit_reg <= key_match;
                    if (key_match || pos_reg == last_pos)
                    begin
                        state_reg <= ST_UPD;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + AW'(1);
                        state_reg <= ST_ORD;
                    end
                end
                ST_UPD:
                begin
                    state_reg <= (pos_reg == '0) ? ST_TOP : ST_SH_RD;
                end
                ST_SH_RD:
                begin
                    state_reg <= ST_SH_WR;
                end
                ST_SH_WR:
                begin
                    pos_reg   <= pos_reg - AW'(1);
                    state_reg <= (pos_reg == AW'(1)) ? ST_TOP : ST_SH_RD;
                end
                ST_TOP:
                begin
                    quo_reg   <= slot_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= DCW'(AW);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // one restoring divide step per cycle
                    rem_reg <= div_ge ? CPR_W'(rem_sh - {1'b0, cpr_reg}) : CPR_W'(rem_sh);
                    quo_reg <= (quo_reg << 1) | AW'(div_ge);
                    cnt_reg <= cnt_reg - DCW'(1);
                    if (cnt_reg == DCW'(1))
                    begin
                        state_reg <= ST_MULX;
                    end
                end
                ST_MULX:
                begin
                    x_reg     <= prod[COORD_W-1:0];
                    state_reg <= ST_MULY;
                end
                ST_MULY:
                begin
                    y_reg     <= prod[COORD_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (zero_reg)
                        begin
                            m_tuser_reg <= 1'b0;
                            m_tdata_reg <= '0;
                        end
                        else
                        begin
                            m_tuser_reg <= hit_reg;
                            m_tdata_reg <= {6'd0, h_rd_reg, w_rd_reg, y_reg, x_reg};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_INIT;
                end
            endcase
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BLOCK_SIZE:    bs_reg  <= cfg_data[BS_W-1:0];
                    REG_CELLS_PER_ROW: cpr_reg <= cfg_data[CPR_W-1:0];
                    default:
                    begin
                    end
                endcase
                swp_reg   <= '0;
                state_reg <= ST_INIT;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (state_reg == ST_INIT) && !s_tready)
        else $error("configuration write did not start init sweep");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ORD || state_reg == ST_KEY || state_reg == ST_CMP)
        |-> (CW'(pos_reg) < active_cnt))
        else $error("search position beyond active slots");

    a_col_below_cpr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULX) |-> (rem_reg < cpr_reg))
        else $error("column remainder out of range");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for glyph_slot_lru_cache: directed rows then random lookups and clears
// over several geometries, each result checked against an in-bench LRU predictor
// or a fixed expected result. Depends on gslc_pkg and the glyph_slot_lru_cache RTL.
module tb;
    import gslc_pkg::*;

    localparam int SLOTS = 64;
    localparam int NUM_ROWS = 20;
    localparam int NUM_PHASES = 7;

    typedef struct packed {
        logic                hit;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
    } glyph_res_t;

    typedef struct packed {
        logic                func;
        logic [CODE_W-1:0]   code;
        logic [CODE_W-1:0]   font;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
        logic                known;
        glyph_res_t          res;
    } glyph_req_t;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_t;

    typedef struct packed {
        cfg_data_t   bs;
        cfg_data_t   cpr;
        flow_t       flow;
        logic [9:0]  count;
        logic [4:0]  pool_len;
    } phase_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    in_data_t   s_tdata;
    logic       s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    out_data_t  m_tdata;
    logic       m_tuser;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    glyph_slot_lru_cache #(.ENTRIES(SLOTS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [KEY_W-1:0]  key_mem [SLOTS];
    logic [SIZE_W-1:0] wid_mem [SLOTS];
    logic [SIZE_W-1:0] hgt_mem [SLOTS];
    int                lru_order [SLOTS];   // position 0 is most recent
    int                n_active;
    logic [BS_W-1:0]   blk;
    logic [CPR_W-1:0]  cpr;

    glyph_res_t        cell_q[$];
    logic [KEY_W-1:0]  key_pool [16];
    flow_t             flow_mode;
    int                err_cnt = 0;

    localparam glyph_req_t DIR_ROWS [NUM_ROWS] = '{
        '{FUNC_LOOKUP, 16'h0000, 16'h0000, 8'h12, 8'h34, 1'b1,
          '{1'b1, 9'd112, 9'd112, 8'h00, 8'h00}},
        '{FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
          '{1'b0, 9'd0, 9'd0, 8'hFF, 8'hFF}},
        '{FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1,
          '{1'b1, 9'd0, 9'd0, 8'hFF, 8'hFF}},
        '{FUNC_LOOKUP, 16'h0041, 16'h0000, 8'h00, 8'h80, 1'b1,
          '{1'b0, 9'd16, 9'd0, 8'h00, 8'h80}},
        '{FUNC_LOOKUP, 16'h0041, 16'h0001, 8'h55, 8'hAA, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0041, 16'h8000, 8'hAA, 8'h55, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h8000, 16'h0000, 8'h01, 8'h02, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0000, 16'h0000, 8'h77, 8'h77, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0041, 16'h0000, 8'h00, 8'h00, 1'b0, '0},
        '{FUNC_CLEAR,  16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, '0},
        '{FUNC_LOOKUP, 16'h0000, 16'h0000, 8'h33, 8'h44, 1'b0, '0},
        '{FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 8'h10, 8'h20, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0001, 16'h0000, 8'h7F, 8'hFE, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0000, 16'h0001, 8'h80, 8'h01, 1'b0, '0},
        '{FUNC_CLEAR,  16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, '0},
        '{FUNC_LOOKUP, 16'h5555, 16'hAAAA, 8'h5A, 8'hA5, 1'b0, '0},
        '{FUNC_LOOKUP, 16'hAAAA, 16'h5555, 8'hA5, 8'h5A, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h5555, 16'hAAAA, 8'h00, 8'h00, 1'b0, '0},
        '{FUNC_LOOKUP, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0, '0},
        '{FUNC_LOOKUP, 16'h0000, 16'h0000, 8'hC3, 8'h3C, 1'b0, '0}
    };

    // block_size, cells_per_row write data (masked to 4 bits), flow, items, key pool
    localparam phase_t PHASES [NUM_PHASES] = '{
        '{7'd16,  7'd8,   FLOW_FREE,      10'd150, 5'd16},
        '{7'd64,  7'd2,   FLOW_SRC_IDLE,  10'd100, 5'd6},
        '{7'd1,   7'd1,   FLOW_SNK_STALL, 10'd80,  5'd3},
        '{7'd127, 7'd15,  FLOW_BOTH,      10'd150, 5'd16},
        '{7'd0,   7'd0,   FLOW_FREE,      10'd30,  5'd4},
        '{7'd37,  7'h73,  FLOW_SRC_IDLE,  10'd100, 5'd8},
        '{7'd5,   7'd4,   FLOW_BOTH,      10'd100, 5'd12}
    };

    function automatic void reset_cache();
        n_active = int'(cpr) * int'(cpr);
        if (n_active > SLOTS)
            n_active = SLOTS;
        for (int p = 0; p < SLOTS; p++)
        begin
            key_mem[p] = '0;
            wid_mem[p] = '0;
            hgt_mem[p] = '0;
            lru_order[p] = (p < n_active) ? n_active - 1 - p : 0;
        end
    endfunction

    function automatic glyph_res_t predict_cell(glyph_req_t rq);
        logic [KEY_W-1:0] key;
        glyph_res_t       r;
        int               pos;
        int               slot;
        int               xp;
        int               yp;
        key = {rq.font, rq.code};
        r = '0;
        if (rq.func == FUNC_CLEAR)
        begin
            for (int p = 0; p < SLOTS; p++)
                key_mem[p] = '0;
            return r;
        end
        if (n_active == 0)
            return r;
        pos = n_active;
        for (int p = 0; p < n_active; p++)
        begin
            if (key_mem[lru_order[p]] == key)
            begin
                pos = p;
                break;
            end
        end
        r.hit = (pos < n_active);
        if (!r.hit)
            pos = n_active - 1;
        slot = lru_order[pos];
        if (!r.hit)
        begin
            key_mem[slot] = key;
            wid_mem[slot] = rq.w;
            hgt_mem[slot] = rq.h;
        end
        for (int p = pos; p > 0; p--)
            lru_order[p] = lru_order[p - 1];
        lru_order[0] = slot;
        xp = (slot % int'(cpr)) * int'(blk);
        yp = (slot / int'(cpr)) * int'(blk);
        r.x = xp[COORD_W-1:0];
        r.y = yp[COORD_W-1:0];
        r.w = wid_mem[slot];
        r.h = hgt_mem[slot];
        return r;
    endfunction

    function automatic bit gap_now(bit sink);
        int pct;
        pct = 0;
        if (flow_mode == FLOW_BOTH)
            pct = 34;
        else if ((sink && flow_mode == FLOW_SNK_STALL) || (!sink && flow_mode == FLOW_SRC_IDLE))
            pct = 59;
        return $urandom_range(99) < pct;
    endfunction

    function automatic glyph_req_t random_req(int pool_len);
        glyph_req_t rq;
        int         r;
        rq = '0;
        r = $urandom_range(99);
        rq.code = CODE_W'($urandom);
        rq.font = CODE_W'($urandom);
        rq.w = SIZE_W'($urandom);
        rq.h = SIZE_W'($urandom);
        rq.func = FUNC_LOOKUP;
        if (r < 5)
            rq.func = FUNC_CLEAR;
        else if (r < 15)
        begin
            rq.code = '0;
            rq.font = '0;
        end
        else if (r < 80)
            {rq.font, rq.code} = key_pool[$urandom_range(pool_len - 1)];
        else if (r < 88)
        begin
            rq.code = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            rq.font = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
        return rq;
    endfunction

    task automatic send_req(glyph_req_t rq);
        glyph_res_t pred;
        while (gap_now(1'b0))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.func;
        s_tdata  <= {rq.h, rq.w, rq.font, rq.code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_cell(rq);
        cell_q.push_back(rq.known ? rq.res : pred);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (cell_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_data_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_BLOCK_SIZE)
            blk = val[BS_W-1:0];
        else
            cpr = val[CPR_W-1:0];
        reset_cache();
    endtask

    always @(posedge clk)
        m_tready <= !gap_now(1'b1);

    always @(posedge clk)
    begin
        glyph_res_t got;
        glyph_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[8:0], m_tdata[17:9], m_tdata[25:18], m_tdata[33:26]};
            if (cell_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected transaction: hit=%0d x=%0d y=%0d w=%0d h=%0d",
                             got.hit, got.x, got.y, got.w, got.h);
            end
            else
            begin
                want = cell_q.pop_front();
                if (got != want)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("mismatch: exp hit=%0d x=%0d y=%0d w=%0d h=%0d",
                                 want.hit, want.x, want.y, want.w, want.h);
                        $display("          got hit=%0d x=%0d y=%0d w=%0d h=%0d",
                                 got.hit, got.x, got.y, got.w, got.h);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_LOOKUP;
        cfg_we    = 1'b0;
        cfg_index = REG_BLOCK_SIZE;
        cfg_data  = '0;
        flow_mode = FLOW_FREE;
        blk = 7'd16;
        cpr = 4'd8;
        reset_cache();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_req(DIR_ROWS[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            write_reg(REG_BLOCK_SIZE, PHASES[ph].bs);
            write_reg(REG_CELLS_PER_ROW, PHASES[ph].cpr);
            cfg_we <= 1'b0;
            for (int k = 0; k < 16; k++)
                key_pool[k] = $urandom;
            flow_mode = PHASES[ph].flow;
            for (int k = 0; k < int'(PHASES[ph].count); k++)
                send_req(random_req(int'(PHASES[ph].pool_len)));
        end

        drain();
        repeat (400) @(posedge clk);
        if (err_cnt == 0 && cell_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gslc_pkg.sv
hdl/glyph_slot_lru_cache.sv
sim/tb.sv
